// ----- design/hps_pkg.sv -----
// ----------------------------------------------------------------------------
// Haptic pulse sequencer package
// Shared types, register indexes and reset values for the sequencer blocks.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int CFG_WIDTH    = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic {
        CMD_TICK    = 1'b0,
        CMD_TRIGGER = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        PAT_NONE  = 2'd0,
        PAT_CLICK = 2'd1,
        PAT_DONE  = 2'd2,
        PAT_ERROR = 2'd3
    } t_pattern;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CLICK_ON  = 3'd0,
        REG_DONE_ON   = 3'd1,
        REG_DONE_OFF  = 3'd2,
        REG_ERROR_ON  = 3'd3,
        REG_ERROR_OFF = 3'd4
    } t_reg_idx;

    localparam logic [CFG_WIDTH-1:0] RST_CLICK_ON  = 16'd30;
    localparam logic [CFG_WIDTH-1:0] RST_DONE_ON   = 16'd45;
    localparam logic [CFG_WIDTH-1:0] RST_DONE_OFF  = 16'd55;
    localparam logic [CFG_WIDTH-1:0] RST_ERROR_ON  = 16'd75;
    localparam logic [CFG_WIDTH-1:0] RST_ERROR_OFF = 16'd60;

    // Pulses still to start after the first one, per pattern.
    localparam logic [1:0] CLICK_EXTRA = 2'd0;
    localparam logic [1:0] DONE_EXTRA  = 2'd1;
    localparam logic [1:0] ERROR_EXTRA = 2'd2;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] click_on;
        logic [CFG_WIDTH-1:0] done_on;
        logic [CFG_WIDTH-1:0] done_off;
        logic [CFG_WIDTH-1:0] error_on;
        logic [CFG_WIDTH-1:0] error_off;
    } t_cfg;

endpackage

// ----- design/hps_if.sv -----
// ----------------------------------------------------------------------------
// Haptic pulse sequencer channels
// Valid/ready request channels for input items and result items.
// ----------------------------------------------------------------------------
interface hps_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [1:0] pattern;

    modport source (output valid, command, pattern, input ready);
    modport sink   (input valid, command, pattern, output ready);
endinterface

interface hps_out_if;
    logic       valid;
    logic       ready;
    logic       motor_on;
    logic       busy_res;
    logic [1:0] pulses_left;

    modport source (output valid, motor_on, busy_res, pulses_left, input ready);
    modport sink   (input valid, motor_on, busy_res, pulses_left, output ready);
endinterface

// ----- design/haptic_pulse_sequencer.sv -----
// ----------------------------------------------------------------------------
// Haptic pulse sequencer
// Drives a vibration motor through click, done and error pulse trains.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  i_req     in         command (tick or trigger), pattern
//  o_rsp     out        motor_on, busy_res, pulses_left
//  i_cfg_*   in         write enable, register index, 16-bit write data
//
//  Each request passes an input register and then a result register; one
//  request per cycle is sustained while results are taken. The sequencer core
//  does the state update for a request as it moves to the result register.
//  A stalled result holds the core; the input register takes one more request
//  and then the request side stalls until the result is taken.
//  Reset is synchronous and restores the register defaults and an idle motor.
// ----------------------------------------------------------------------------
module haptic_pulse_sequencer #(
    parameter int DURATION_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hps_in_if.sink                           i_req,
    hps_out_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [hps_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [hps_pkg::CFG_WIDTH-1:0]    i_cfg_wdata
);
    import hps_pkg::*;

    t_cfg       cfg;
    logic       r_in_valid;
    logic       r_in_command;
    logic [1:0] r_in_pattern;
    logic       r_out_valid;
    logic       r_out_motor;
    logic       r_out_busy;
    logic [1:0] r_out_pulses;
    logic       out_free;
    logic       advance;
    logic       seq_motor;
    logic       seq_busy;
    logic [1:0] seq_pulses;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign advance     = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;

    hps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    hps_seq #(
        .DURATION_BITS (DURATION_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_command     (r_in_command),
        .i_pattern     (r_in_pattern),
        .i_cfg         (cfg),
        .o_motor_on    (seq_motor),
        .o_busy        (seq_busy),
        .o_pulses_left (seq_pulses)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_command <= i_req.command;
            r_in_pattern <= i_req.pattern;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_motor  <= seq_motor;
            r_out_busy   <= seq_busy;
            r_out_pulses <= seq_pulses;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.motor_on    = r_out_motor;
    assign o_rsp.busy_res    = r_out_busy;
    assign o_rsp.pulses_left = r_out_pulses;

endmodule

// ----- design/hps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Haptic pulse sequencer configuration registers
// Holds the five pulse timing registers written through the plain write port.
// ----------------------------------------------------------------------------
module hps_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hps_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [hps_pkg::CFG_WIDTH-1:0]    i_cfg_wdata,
    output hps_pkg::t_cfg                    o_cfg
);
    import hps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.click_on  <= RST_CLICK_ON;
            r_cfg.done_on   <= RST_DONE_ON;
            r_cfg.done_off  <= RST_DONE_OFF;
            r_cfg.error_on  <= RST_ERROR_ON;
            r_cfg.error_off <= RST_ERROR_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CLICK_ON:  r_cfg.click_on  <= i_cfg_wdata;
                REG_DONE_ON:   r_cfg.done_on   <= i_cfg_wdata;
                REG_DONE_OFF:  r_cfg.done_off  <= i_cfg_wdata;
                REG_ERROR_ON:  r_cfg.error_on  <= i_cfg_wdata;
                REG_ERROR_OFF: r_cfg.error_off <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/hps_seq.sv -----
// ----------------------------------------------------------------------------
// Haptic pulse sequencer core
// Pulse train state and its single-cycle update for one tick or trigger.
// ----------------------------------------------------------------------------
module hps_seq #(
    parameter int DURATION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_command,
    input  logic [1:0]    i_pattern,
    input  hps_pkg::t_cfg i_cfg,
    output logic          o_motor_on,
    output logic          o_busy,
    output logic [1:0]    o_pulses_left
);
    import hps_pkg::*;

    localparam int DB = DURATION_BITS;

    logic          r_active, n_active;
    logic          r_motor, n_motor;
    logic [1:0]    r_pending, n_pending;
    logic [DB-1:0] r_remain, n_remain;
    logic [DB-1:0] r_lat_on, n_lat_on;
    logic [DB-1:0] r_lat_off, n_lat_off;

    logic [CFG_WIDTH-1:0] sel_on;
    logic [CFG_WIDTH-1:0] sel_off;
    logic [1:0]           sel_extra;
    logic [DB-1:0]        fit_on;
    logic [DB-1:0]        fit_off;
    logic [DB-1:0]        dec;

    always_comb begin
        case (t_pattern'(i_pattern))
            PAT_CLICK: begin
                sel_on    = i_cfg.click_on;
                sel_off   = '0;
                sel_extra = CLICK_EXTRA;
            end
            PAT_DONE: begin
                sel_on    = i_cfg.done_on;
                sel_off   = i_cfg.done_off;
                sel_extra = DONE_EXTRA;
            end
            PAT_ERROR: begin
                sel_on    = i_cfg.error_on;
                sel_off   = i_cfg.error_off;
                sel_extra = ERROR_EXTRA;
            end
            default: begin
                sel_on    = '0;
                sel_off   = '0;
                sel_extra = '0;
            end
        endcase
    end

    // Register values wider than the countdown saturate to its full scale.
    if (DB >= CFG_WIDTH) begin : g_wide
        assign fit_on  = DB'(sel_on);
        assign fit_off = DB'(sel_off);
    end else begin : g_narrow
        assign fit_on  = (|sel_on[CFG_WIDTH-1:DB])  ? {DB{1'b1}} : sel_on[DB-1:0];
        assign fit_off = (|sel_off[CFG_WIDTH-1:DB]) ? {DB{1'b1}} : sel_off[DB-1:0];
    end

    assign dec = (r_remain != '0) ? r_remain - DB'(1) : '0;

    always_comb begin
        n_active  = r_active;
        n_motor   = r_motor;
        n_pending = r_pending;
        n_remain  = r_remain;
        n_lat_on  = r_lat_on;
        n_lat_off = r_lat_off;
        if (i_command == CMD_TRIGGER) begin
            if (t_pattern'(i_pattern) == PAT_NONE) begin
                n_active  = 1'b0;
                n_motor   = 1'b0;
                n_pending = '0;
                n_remain  = '0;
            end else begin
                n_active  = 1'b1;
                n_motor   = 1'b1;
                n_pending = sel_extra;
                n_lat_on  = fit_on;
                n_lat_off = fit_off;
                n_remain  = fit_on;
            end
        end else if (r_active) begin
            n_remain = dec;
            if (dec == '0) begin
                if (r_motor) begin
                    n_motor = 1'b0;
                    if (r_pending == '0) begin
                        n_active = 1'b0;
                    end else begin
                        n_remain = r_lat_off;
                    end
                end else begin
                    n_motor   = 1'b1;
                    n_pending = r_pending - 2'd1;
                    n_remain  = r_lat_on;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_motor   <= 1'b0;
            r_pending <= '0;
            r_remain  <= '0;
            r_lat_on  <= '0;
            r_lat_off <= '0;
        end else if (i_en) begin
            r_active  <= n_active;
            r_motor   <= n_motor;
            r_pending <= n_pending;
            r_remain  <= n_remain;
            r_lat_on  <= n_lat_on;
            r_lat_off <= n_lat_off;
        end
    end

    assign o_motor_on    = n_motor;
    assign o_busy        = n_active;
    assign o_pulses_left = n_pending;

endmodule

// ----- design/hps_checker.sv -----
// ----------------------------------------------------------------------------
// Haptic pulse sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module hps_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_motor_on,
    input logic       i_busy_res,
    input logic [1:0] i_pulses_left
);

    // An idle sequence has the motor off and nothing left to start.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_busy_res |-> !i_motor_on && i_pulses_left == 2'd0)
        else $error("idle result with motor on or pulses left");

    a_pulses_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_pulses_left != 2'd3)
        else $error("pulses_left out of range");

    // With the result register empty, the input side never stalls.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request stalled with empty result register");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind haptic_pulse_sequencer hps_props u_hps_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_motor_on    (o_rsp.motor_on),
    .i_busy_res    (o_rsp.busy_res),
    .i_pulses_left (o_rsp.pulses_left)
);
